>>> src/numa_morsel_dispatcher_assert.svh
// ----------------------------------------------------------------------------
// numa morsel dispatcher assertion macros
// concurrent checks on clk_i with the async reset as disable condition
// ----------------------------------------------------------------------------
`ifndef NUMA_MORSEL_DISPATCHER_ASSERT_SVH
`define NUMA_MORSEL_DISPATCHER_ASSERT_SVH

`ifndef SYNTHESIS
`define NMD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NMD_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define NMD_ASSERT(label, prop, msg)
`define NMD_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> src/nmd_pkg.sv
// ----------------------------------------------------------------------------
// nmd_pkg
// widths, types and codes of the numa morsel dispatcher
// ----------------------------------------------------------------------------
`default_nettype none

package nmd_pkg;

  localparam int unsigned MaxNodes = 8;
  localparam int unsigned RowW     = 48;
  localparam int unsigned NodeW    = $clog2(MaxNodes);
  localparam int unsigned CntW     = NodeW + 1;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned WorkerW  = 8;
  localparam int unsigned DivSteps = RowW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  typedef logic [RowW-1:0]     row_t;
  typedef logic [NodeW-1:0]    node_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [SizeW-1:0]    size_t;
  typedef logic [WorkerW-1:0]  worker_t;
  typedef logic [MaxNodes-1:0] mask_t;
  typedef logic [1:0]          cfg_idx_t;

  localparam cfg_idx_t CfgTotalRows  = 2'd0;
  localparam cfg_idx_t CfgNodeCount  = 2'd1;
  localparam cfg_idx_t CfgEnableMask = 2'd2;

  localparam logic CmdStart = 1'b0;

  localparam row_t RowMax = '1;

endpackage

`default_nettype wire

>>> src/numa_morsel_dispatcher.sv
// ----------------------------------------------------------------------------
// numa_morsel_dispatcher
// hands out row ranges of a job to workers on up to eight memory nodes
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// command   in         start_i, busy_o       command, home_node, chunk_rows,
//                                            worker_id
// result    out        done_o (strobe)       granted, first_row, end_row,
//                                            served_node, worker_echo
// config    in         cfg_we_i              cfg_idx_i, cfg_wdata_i
//
// one 49-bit add/subtract unit serves divide, partition, scan, grant, clip
// start: 48 divide steps, then 8 node writes; with no enabled node only
//   the node writes
// request: home node compared first, else one node compared per cycle from
//   node 0, then add and clip; a node count of zero gives no grant
// busy_o is high from acceptance until the result strobe; the result is
//   shown for one cycle and cannot be held off
// reset clears configuration to its defaults and all node ranges to empty
// ----------------------------------------------------------------------------
`default_nettype none
`include "numa_morsel_dispatcher_assert.svh"

module numa_morsel_dispatcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              command_i,
  input  nmd_pkg::node_t    home_node_i,
  input  nmd_pkg::size_t    chunk_rows_i,
  input  nmd_pkg::worker_t  worker_id_i,
  input  logic              cfg_we_i,
  input  nmd_pkg::cfg_idx_t cfg_idx_i,
  input  nmd_pkg::row_t     cfg_wdata_i,
  output logic              done_o,
  output logic              granted_o,
  output nmd_pkg::row_t     first_row_o,
  output nmd_pkg::row_t     end_row_o,
  output nmd_pkg::node_t    served_node_o,
  output nmd_pkg::worker_t  worker_echo_o
);

  import nmd_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SPart  = 3'd2;
  localparam logic [2:0] SHome  = 3'd3;
  localparam logic [2:0] SScan  = 3'd4;
  localparam logic [2:0] SGrant = 3'd5;
  localparam logic [2:0] SClip  = 3'd6;

  // configuration
  row_t    total_rows_q;
  cnt_t    node_count_q;
  mask_t   enable_q;

  // node ranges
  row_t    next_q [MaxNodes];
  row_t    end_q  [MaxNodes];

  // sequencer and working registers
  logic [2:0]       state_q;
  node_t            idx_q;
  logic [StepW-1:0] step_q;
  row_t             quo_q;
  logic [NodeW-1:0] rem_q;
  row_t             acc_q;
  cnt_t             k_q;
  size_t            size_q;
  worker_t          worker_q;
  row_t             sum_q;

  // result registers
  logic    done_q;
  logic    granted_q;
  row_t    first_q;
  row_t    endr_q;
  node_t   served_q;
  worker_t echo_q;

  cnt_t    scan_n;
  mask_t   scan_mask;
  cnt_t    avail;

  logic [RowW:0] alu_a;
  logic [RowW:0] alu_b;
  logic [RowW:0] alu_res;
  logic          alu_sub;
  logic          alu_borrow;

  logic [NodeW:0] div_r;
  row_t           sat_sum;
  logic           part_en;
  logic           accept;

  // effective node count and enabled nodes inside it
  always_comb begin
    scan_n = (node_count_q > cnt_t'(MaxNodes)) ? cnt_t'(MaxNodes) : node_count_q;
    avail  = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      scan_mask[i] = enable_q[i] && (cnt_t'(i) < scan_n);
      avail        = avail + cnt_t'(scan_mask[i]);
    end
  end

  assign div_r   = {rem_q, quo_q[RowW-1]};
  assign part_en = scan_mask[idx_q] && (avail != '0);
  assign accept  = start_i && (state_q == SIdle);

  // shared adder: operand selection by sequencer state
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      SDiv: begin
        alu_a   = (RowW+1)'(div_r);
        alu_b   = (RowW+1)'(avail);
        alu_sub = 1'b1;
      end
      SPart: begin
        alu_a = {1'b0, acc_q};
        alu_b = {1'b0, quo_q};
      end
      SHome, SScan: begin
        alu_a   = {1'b0, next_q[idx_q]};
        alu_b   = {1'b0, end_q[idx_q]};
        alu_sub = 1'b1;
      end
      SGrant: begin
        alu_a = {1'b0, next_q[idx_q]};
        alu_b = (RowW+1)'(size_q);
      end
      SClip: begin
        alu_a   = {1'b0, sum_q};
        alu_b   = {1'b0, end_q[idx_q]};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_res    = alu_a + (alu_sub ? ~alu_b : alu_b) + (RowW+1)'(alu_sub);
  assign alu_borrow = alu_res[RowW];
  assign sat_sum    = alu_borrow ? RowMax : alu_res[RowW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_rows_q <= '0;
      node_count_q <= cnt_t'(1);
      enable_q     <= mask_t'(1);
      for (int i = 0; i < MaxNodes; i++) begin
        next_q[i] <= '0;
        end_q[i]  <= '0;
      end
      state_q   <= SIdle;
      idx_q     <= '0;
      step_q    <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      acc_q     <= '0;
      k_q       <= '0;
      size_q    <= '0;
      worker_q  <= '0;
      sum_q     <= '0;
      done_q    <= 1'b0;
      granted_q <= 1'b0;
      first_q   <= '0;
      endr_q    <= '0;
      served_q  <= '0;
      echo_q    <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTotalRows:  total_rows_q <= cfg_wdata_i;
          CfgNodeCount:  node_count_q <= cfg_wdata_i[CntW-1:0];
          CfgEnableMask: enable_q     <= cfg_wdata_i[MaxNodes-1:0];
          default: ;
        endcase
      end

      case (state_q)
        SIdle: begin
          if (accept) begin
            worker_q <= worker_id_i;
            if (command_i == CmdStart) begin
              idx_q  <= '0;
              acc_q  <= '0;
              k_q    <= '0;
              quo_q  <= total_rows_q;
              rem_q  <= '0;
              step_q <= '0;
              state_q <= (avail == '0) ? SPart : SDiv;
            end else begin
              // zero size is served as one row
              size_q  <= (chunk_rows_i == '0) ? size_t'(1) : chunk_rows_i;
              idx_q   <= home_node_i;
              state_q <= SHome;
            end
          end
        end

        SDiv: begin
          // restoring divide, one quotient bit a cycle
          rem_q <= alu_borrow ? div_r[NodeW-1:0] : alu_res[NodeW-1:0];
          quo_q <= {quo_q[RowW-2:0], !alu_borrow};
          if (step_q == StepW'(DivSteps - 1)) begin
            state_q <= SPart;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end

        SPart: begin
          if (part_en) begin
            next_q[idx_q] <= acc_q;
            // last enabled node takes the remainder
            end_q[idx_q]  <= (k_q == avail - cnt_t'(1)) ? total_rows_q : alu_res[RowW-1:0];
            acc_q         <= alu_res[RowW-1:0];
            k_q           <= k_q + cnt_t'(1);
          end else begin
            next_q[idx_q] <= '0;
            end_q[idx_q]  <= '0;
          end
          if (idx_q == node_t'(MaxNodes - 1)) begin
            done_q    <= 1'b1;
            granted_q <= 1'b0;
            first_q   <= '0;
            endr_q    <= '0;
            served_q  <= '0;
            echo_q    <= worker_q;
            state_q   <= SIdle;
          end else begin
            idx_q <= idx_q + node_t'(1);
          end
        end

        SHome: begin
          if (({1'b0, idx_q} < scan_n) && alu_borrow) begin
            state_q <= SGrant;
          end else if (scan_n == '0) begin
            done_q    <= 1'b1;
            granted_q <= 1'b0;
            first_q   <= '0;
            endr_q    <= '0;
            served_q  <= '0;
            echo_q    <= worker_q;
            state_q   <= SIdle;
          end else begin
            idx_q   <= '0;
            state_q <= SScan;
          end
        end

        SScan: begin
          if (alu_borrow) begin
            state_q <= SGrant;
          end else if (({1'b0, idx_q} + cnt_t'(1)) == scan_n) begin
            // every scanned node is exhausted
            done_q    <= 1'b1;
            granted_q <= 1'b0;
            first_q   <= '0;
            endr_q    <= '0;
            served_q  <= '0;
            echo_q    <= worker_q;
            state_q   <= SIdle;
          end else begin
            idx_q <= idx_q + node_t'(1);
          end
        end

        SGrant: begin
          first_q       <= next_q[idx_q];
          next_q[idx_q] <= sat_sum;
          sum_q         <= sat_sum;
          state_q       <= SClip;
        end

        SClip: begin
          endr_q    <= alu_borrow ? sum_q : end_q[idx_q];
          done_q    <= 1'b1;
          granted_q <= 1'b1;
          served_q  <= idx_q;
          echo_q    <= worker_q;
          state_q   <= SIdle;
        end

        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign busy_o        = (state_q != SIdle);
  assign done_o        = done_q;
  assign granted_o     = granted_q;
  assign first_row_o   = first_q;
  assign end_row_o     = endr_q;
  assign served_node_o = served_q;
  assign worker_echo_o = echo_q;

  `NMD_ASSERT(busy_after_accept_a, start_i && !busy_o |=> busy_o, "accepted item did not raise busy")
  `NMD_ASSERT(strobe_idle_a, done_o |-> !busy_o, "result strobe while still busy")
  `NMD_ASSERT(grant_strobe_a, granted_o && done_o |-> first_row_o < end_row_o, "empty grant range")
  `NMD_ASSERT_NEVER(div_zero_a, state_q == SDiv && avail == '0, "divide with no enabled node")
  `NMD_ASSERT(scan_range_a, state_q == SScan |-> ({1'b0, idx_q} < scan_n), "scan past node count")

endmodule

`default_nettype wire
